>>> rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the streaming pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int PosW     = 32;
  localparam int LenFldW  = 5;

  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd2;

  typedef struct packed {
    logic [7:0]      text_byte;
    logic            start;
    logic [PosW-1:0] pos;
  } kmp_item_t;

  typedef struct packed {
    logic building;
    logic clear;
  } kmp_stat_t;

endpackage

>>> rtl/core/kmp_stream_matcher_unit.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher_unit
// Streaming pattern matcher: reports where a pattern of up to MAX_PATTERN
// bytes starts in a byte stream, overlapping matches included.
// ----------------------------------------------------------------------------
// Text bytes enter on the in channel, one byte per beat, with a flag that
// marks the first byte of a new text. Each full match yields one beat on
// the out channel carrying the 0-based start index; other bytes yield none.
// The pattern and its length are set through the write port; the failure
// table is built from them. Every write to the pattern or length registers
// rebuilds the failure table, and the input stalls meanwhile.
// An accepted byte waits in a two-entry queue; the matcher then follows
// failure links one step at a time until the byte matches or no link is
// left, and then takes the byte off the queue. A match start is registered
// in the output register as its last byte leaves the queue.
// After reset the length is zero and no match is reported. While the
// receiver stalls, the result is held, the matcher stops on its next match
// and the queue fills, after which the input stalls.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_unit #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   text_byte_i,
  input  logic                         start_of_text_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kmp_pkg::PosW-1:0]     match_start_o
);
  import kmp_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN);
  localparam int CW = $clog2(MAX_PATTERN + 1);

  kmp_stat_t     stat;
  kmp_item_t     push_item, head_item;
  logic          push, pop, q_full, q_empty;
  logic [IW-1:0] rd_idx, link, last_link, matched;
  logic [7:0]    pat_byte;
  logic [CW-1:0] len;

  kmp_table #(.MAX_PATTERN(MAX_PATTERN)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_idx_i    (rd_idx),
    .pat_byte_o  (pat_byte),
    .link_o      (link),
    .len_o       (len),
    .last_link_o (last_link),
    .stat_o      (stat)
  );

  kmp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .text_byte_i     (text_byte_i),
    .start_of_text_i (start_of_text_i),
    .in_stall_o      (in_stall_o),
    .q_full_i        (q_full),
    .stat_i          (stat),
    .push_o          (push),
    .item_o          (push_item)
  );

  kmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  kmp_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .item_i        (head_item),
    .pop_o         (pop),
    .stat_i        (stat),
    .len_i         (len),
    .last_link_i   (last_link),
    .pat_byte_i    (pat_byte),
    .link_i        (link),
    .rd_idx_o      (rd_idx),
    .matched_o     (matched),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_start_o (match_start_o)
  );

  a_build_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.building |-> in_stall_o)
    else $error("input accepted while the failure table is rebuilt");

  a_matched_below_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len != '0) |-> (CW'(matched) < len))
    else $error("matched length reached the pattern length");

  a_match_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_empty))
    else $error("match reported without a queued byte");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

>>> rtl/core/kmp_table.sv
// ----------------------------------------------------------------------------
// kmp_table
// Configuration registers, pattern store and failure table builder.
// ----------------------------------------------------------------------------
module kmp_table #(
  parameter int  MAX_PATTERN = 16,
  localparam int IW          = $clog2(MAX_PATTERN),
  localparam int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kmp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [IW-1:0]                rd_idx_i,
  output logic [7:0]                   pat_byte_o,
  output logic [IW-1:0]                link_o,
  output logic [CW-1:0]                len_o,
  output logic [IW-1:0]                last_link_o,
  output kmp_pkg::kmp_stat_t           stat_o
);
  import kmp_pkg::*;

  typedef enum logic {StIdle, StBuild} state_e;

  state_e        state_q, state_d;
  logic [7:0]    pat_q [MAX_PATTERN];
  logic [7:0]    pat_d [MAX_PATTERN];
  logic [7:0]    sh_q  [MAX_PATTERN];
  logic [7:0]    sh_d  [MAX_PATTERN];
  logic [IW-1:0] ft_q  [MAX_PATTERN];
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] k_q, k_d;
  logic [IW-1:0] plen_q, plen_d;
  logic [IW-1:0] last_q, last_d;
  logic          cfg_hit;
  logic [IW-1:0] rd_idx;
  logic [7:0]    pat_rd;
  logic [IW-1:0] link_rd;
  logic          eq;
  logic [IW-1:0] nl;
  logic          ft_we;
  logic [LenFldW-1:0] wlen;

  assign cfg_hit = cfg_we_i && (cfg_index_i == CfgPatLow || cfg_index_i == CfgPatHigh ||
                                cfg_index_i == CfgPatLen);
  assign wlen    = cfg_wdata_i[LenFldW-1:0];

  assign rd_idx  = (state_q == StBuild) ? plen_q : rd_idx_i;
  assign pat_rd  = pat_q[rd_idx];
  assign link_rd = ft_q[rd_idx - 1'b1];
  assign eq      = (sh_q[0] == pat_rd);
  assign nl      = plen_q + IW'(eq);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_d[i] = pat_q[i];
      if (cfg_we_i && cfg_index_i == CfgPatLow && i < 8) begin
        pat_d[i] = cfg_wdata_i[(i % 8) * 8 +: 8];
      end
      if (cfg_we_i && cfg_index_i == CfgPatHigh && i >= 8) begin
        pat_d[i] = cfg_wdata_i[(i % 8) * 8 +: 8];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    k_d     = k_q;
    plen_d  = plen_q;
    last_d  = last_q;
    ft_we   = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sh_d[i] = sh_q[i];
    end
    if (cfg_hit) begin
      state_d = StBuild;
      k_d     = CW'(1);
      plen_d  = '0;
      last_d  = '0;
      if (cfg_index_i == CfgPatLen) begin
        len_d = (wlen > LenFldW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(wlen);
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        sh_d[i] = pat_d[i + 1];
      end
      sh_d[MAX_PATTERN-1] = '0;
    end else if (state_q == StBuild) begin
      if (k_q >= len_q) begin
        state_d = StIdle;
      end else if (plen_q != '0 && !eq) begin
        plen_d = link_rd;
      end else begin
        ft_we  = 1'b1;
        plen_d = nl;
        k_d    = k_q + 1'b1;
        if (k_q == len_q - 1'b1) begin
          last_d = nl;
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          sh_d[i] = sh_q[i + 1];
        end
        sh_d[MAX_PATTERN-1] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q   <= '0;
      k_q     <= '0;
      plen_q  <= '0;
      last_q  <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat_q[i] <= '0;
        sh_q[i]  <= '0;
        ft_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      k_q     <= k_d;
      plen_q  <= plen_d;
      last_q  <= last_d;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pat_q[i] <= pat_d[i];
        sh_q[i]  <= sh_d[i];
      end
      if (ft_we) begin
        ft_q[k_q[IW-1:0]] <= nl;
      end
    end
  end

  assign pat_byte_o     = pat_rd;
  assign link_o         = link_rd;
  assign len_o          = len_q;
  assign last_link_o    = last_q;
  assign stat_o.building = (state_q == StBuild);
  assign stat_o.clear    = cfg_hit;

endmodule

>>> rtl/core/kmp_front.sv
// ----------------------------------------------------------------------------
// kmp_front
// Input side: takes text beats, tracks the saturating text position.
// ----------------------------------------------------------------------------
module kmp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         text_byte_i,
  input  logic               start_of_text_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  input  kmp_pkg::kmp_stat_t stat_i,
  output logic               push_o,
  output kmp_pkg::kmp_item_t item_o
);
  import kmp_pkg::*;

  logic [PosW-1:0] bp_q, bp_d;
  logic [PosW-1:0] pos;

  assign in_stall_o = q_full_i || stat_i.building;
  assign push_o     = in_valid_i && !in_stall_o;
  assign pos        = start_of_text_i ? '0 : bp_q;
  assign bp_d       = (pos == '1) ? pos : pos + 1'b1;

  assign item_o.text_byte = text_byte_i;
  assign item_o.start     = start_of_text_i;
  assign item_o.pos       = pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0;
    end else if (push_o) begin
      bp_q <= bp_d;
    end
  end

endmodule

>>> rtl/core/kmp_queue.sv
// ----------------------------------------------------------------------------
// kmp_queue
// Two-entry queue between the input side and the matcher.
// ----------------------------------------------------------------------------
module kmp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kmp_pkg::kmp_item_t item_i,
  input  logic               pop_i,
  output kmp_pkg::kmp_item_t item_o,
  output logic               full_o,
  output logic               empty_o
);
  import kmp_pkg::*;

  kmp_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign item_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/core/kmp_back.sv
// ----------------------------------------------------------------------------
// kmp_back
// Matcher: walks failure links one step a cycle while no table rebuild runs, and reports match starts.
// ----------------------------------------------------------------------------
module kmp_back #(
  parameter int  MAX_PATTERN = 16,
  localparam int IW          = $clog2(MAX_PATTERN),
  localparam int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  kmp_pkg::kmp_item_t         item_i,
  output logic                       pop_o,
  input  kmp_pkg::kmp_stat_t         stat_i,
  input  logic [CW-1:0]              len_i,
  input  logic [IW-1:0]              last_link_i,
  input  logic [7:0]                 pat_byte_i,
  input  logic [IW-1:0]              link_i,
  output logic [IW-1:0]              rd_idx_o,
  output logic [IW-1:0]              matched_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [kmp_pkg::PosW-1:0]   match_start_o
);
  import kmp_pkg::*;

  logic [IW-1:0]   j_q, j_d;
  logic            busy_q, busy_d;
  logic [IW-1:0]   jcur;
  logic [CW-1:0]   jn;
  logic            eq;
  logic            go;
  logic            out_free;
  logic            emit;
  logic            out_valid_q;
  logic [PosW-1:0] match_q;

  assign jcur     = (!busy_q && item_i.start) ? '0 : j_q;
  assign rd_idx_o = jcur;
  assign eq       = (item_i.text_byte == pat_byte_i);
  assign jn       = CW'(jcur) + CW'(eq);
  assign go       = !q_empty_i && !stat_i.building;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    j_d    = j_q;
    busy_d = busy_q;
    pop_o  = 1'b0;
    emit   = 1'b0;
    if (stat_i.clear) begin
      j_d    = '0;
      busy_d = 1'b0;
    end else if (go) begin
      if (len_i == '0) begin
        j_d    = '0;
        busy_d = 1'b0;
        pop_o  = 1'b1;
      end else if (jcur != '0 && !eq) begin
        j_d    = link_i;
        busy_d = 1'b1;
      end else if (jn == len_i) begin
        if (out_free) begin
          emit   = 1'b1;
          j_d    = last_link_i;
          busy_d = 1'b0;
          pop_o  = 1'b1;
        end else begin
          j_d    = jcur;
          busy_d = 1'b1;
        end
      end else begin
        j_d    = jn[IW-1:0];
        busy_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      j_q    <= j_d;
      busy_q <= busy_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      match_q <= item_i.pos - (PosW'(len_i) - 1'b1);
    end
  end

  assign matched_o     = j_q;
  assign out_valid_o   = out_valid_q;
  assign match_start_o = match_q;

endmodule
